>>> rtl/core/bufuart_pkg.sv
// Package for the buffered UART FIFO block: sizes, command codes, item structs
// and pointer helpers. Used by bufuart_fifo and buffered_uart_fifo_status_top.
package bufuart_pkg;

  localparam int FIFO_SIZE = 16;
  localparam int PTR_W     = (FIFO_SIZE > 1) ? $clog2(FIFO_SIZE) : 1;
  localparam int CNT_W     = 4;
  localparam int DATA_W    = 8;
  localparam int ERR_W     = 5;

  localparam logic [2:0] CMD_LINE_RX  = 3'd0;
  localparam logic [2:0] CMD_HOST_RD  = 3'd1;
  localparam logic [2:0] CMD_HOST_WR  = 3'd2;
  localparam logic [2:0] CMD_LINE_RDY = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  localparam int ERR_FRAME  = 0;
  localparam int ERR_OVRRUN = 1;
  localparam int ERR_PARITY = 2;
  localparam int ERR_RX_OVF = 3;
  localparam int ERR_TX_OVF = 4;

  localparam int STS_FRAME  = 4;
  localparam int STS_OVRRUN = 3;
  localparam int STS_PARITY = 2;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [DATA_W-1:0] data_in;
    logic [7:0]        line_status;
    logic [ERR_W-1:0]  clear_mask;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              push_ok;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_count;
    logic [ERR_W-1:0]  error_flags;
    logic              tx_request_enable;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t n;
    if (p == PTR_W'(FIFO_SIZE - 1)) begin
      n = '0;
    end else begin
      n = p + ptr_t'(1);
    end
    return n;
  endfunction

endpackage

>>> rtl/core/bufuart_fifo.sv
// Ring FIFO with one slot kept free: synchronous registered-read memory plus pointers.
// Depends on bufuart_pkg.
module bufuart_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  bufuart_pkg::fifo_req_t        req,
  input  logic [bufuart_pkg::DATA_W-1:0] din,
  output bufuart_pkg::fifo_stat_t       stat,
  output logic [bufuart_pkg::DATA_W-1:0] rdata
);

  logic [bufuart_pkg::DATA_W-1:0] mem [bufuart_pkg::FIFO_SIZE];
  bufuart_pkg::ptr_t wr_ptr;
  bufuart_pkg::ptr_t rd_ptr;
  logic [bufuart_pkg::PTR_W:0] fill;
  logic [bufuart_pkg::PTR_W+bufuart_pkg::CNT_W:0] fill_ext;

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wr_ptr] <= din;
    end
    if (req.pop) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (req.push) begin
        wr_ptr <= bufuart_pkg::ptr_inc(wr_ptr);
      end
      if (req.pop) begin
        rd_ptr <= bufuart_pkg::ptr_inc(rd_ptr);
      end
    end
  end

  always_comb begin
    fill = {1'b0, wr_ptr} - {1'b0, rd_ptr};
    if (wr_ptr < rd_ptr) begin
      fill = fill + (bufuart_pkg::PTR_W+1)'(bufuart_pkg::FIFO_SIZE);
    end
    fill_ext   = (bufuart_pkg::PTR_W+bufuart_pkg::CNT_W+1)'(fill);
    stat.count = fill_ext[bufuart_pkg::CNT_W-1:0];
    stat.empty = (wr_ptr == rd_ptr);
    stat.full  = (bufuart_pkg::ptr_inc(wr_ptr) == rd_ptr);
  end

endmodule

>>> rtl/core/buffered_uart_fifo_status_top.sv
// Top level of the buffered UART front end: command decode, sticky flags,
// transmit request enable and the result register. Depends on bufuart_pkg, bufuart_fifo.

// Each accepted item is held in the pend register: the FIFO memories are accessed at the
// accept edge and their registered read data lands in the result register in the
// following cycle, so a new item is taken only once the last has left pend and no result
// is stalled. Receive and transmit FIFOs each hold FIFO_SIZE-1 bytes; only one
// item is in flight, so a memory write always completes before any later read.
// Counts report the low four bits of each fill level.
module buffered_uart_fifo_status_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bufuart_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bufuart_pkg::out_item_t out_item
);

  bufuart_pkg::fifo_req_t  rx_req;
  bufuart_pkg::fifo_req_t  tx_req;
  bufuart_pkg::fifo_stat_t rx_stat;
  bufuart_pkg::fifo_stat_t tx_stat;
  logic [bufuart_pkg::DATA_W-1:0] rx_rdata;
  logic [bufuart_pkg::DATA_W-1:0] tx_rdata;

  logic                          accept;
  logic                          pend;
  logic                          pend_valid;
  logic                          pend_tx;
  logic                          pend_ok;
  logic [bufuart_pkg::ERR_W-1:0] errors;
  logic [bufuart_pkg::ERR_W-1:0] errors_next;
  logic                          tx_en;
  logic                          tx_en_next;
  logic                          ok_next;

  bufuart_fifo u_rx_fifo (
    .clk   (clk),
    .rst   (rst),
    .req   (rx_req),
    .din   (in_item.data_in),
    .stat  (rx_stat),
    .rdata (rx_rdata)
  );

  bufuart_fifo u_tx_fifo (
    .clk   (clk),
    .rst   (rst),
    .req   (tx_req),
    .din   (in_item.data_in),
    .stat  (tx_stat),
    .rdata (tx_rdata)
  );

  assign in_stall = pend | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    rx_req      = '0;
    tx_req      = '0;
    errors_next = errors;
    tx_en_next  = tx_en;
    ok_next     = 1'b0;
    unique case (in_item.cmd)
      bufuart_pkg::CMD_LINE_RX: begin
        errors_next[bufuart_pkg::ERR_FRAME]  = errors[bufuart_pkg::ERR_FRAME]
                                             | in_item.line_status[bufuart_pkg::STS_FRAME];
        errors_next[bufuart_pkg::ERR_OVRRUN] = errors[bufuart_pkg::ERR_OVRRUN]
                                             | in_item.line_status[bufuart_pkg::STS_OVRRUN];
        errors_next[bufuart_pkg::ERR_PARITY] = errors[bufuart_pkg::ERR_PARITY]
                                             | in_item.line_status[bufuart_pkg::STS_PARITY];
        if (rx_stat.full) begin
          errors_next[bufuart_pkg::ERR_RX_OVF] = 1'b1;
        end else begin
          rx_req.push = accept;
          ok_next     = 1'b1;
        end
      end
      bufuart_pkg::CMD_HOST_RD: begin
        rx_req.pop = accept & ~rx_stat.empty;
      end
      bufuart_pkg::CMD_HOST_WR: begin
        if (tx_stat.full) begin
          errors_next[bufuart_pkg::ERR_TX_OVF] = 1'b1;
        end else begin
          tx_req.push = accept;
          ok_next     = 1'b1;
          tx_en_next  = 1'b1;
        end
      end
      bufuart_pkg::CMD_LINE_RDY: begin
        if (tx_en) begin
          if (tx_stat.empty) begin
            tx_en_next = 1'b0;
          end else begin
            tx_req.pop = accept;
          end
        end
      end
      bufuart_pkg::CMD_CLEAR: begin
        errors_next = errors & ~in_item.clear_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      errors    <= '0;
      tx_en     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend       <= 1'b1;
        errors     <= errors_next;
        tx_en      <= tx_en_next;
        pend_valid <= rx_req.pop | tx_req.pop;
        pend_tx    <= tx_req.pop;
        pend_ok    <= ok_next;
      end
      if (pend) begin
        pend      <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid & ~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      out_item.data_out          <= pend_valid ? (pend_tx ? tx_rdata : rx_rdata) : '0;
      out_item.data_valid        <= pend_valid;
      out_item.push_ok           <= pend_ok;
      out_item.rx_count          <= rx_stat.count;
      out_item.tx_count          <= tx_stat.count;
      out_item.error_flags       <= errors;
      out_item.tx_request_enable <= tx_en;
    end
  end

endmodule
